@@ rtl/core/fqr_pkg.sv @@
// Shared types and constants for the tag queue with delete-by-value.
`default_nettype none
package fqr_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int OP_W    = 2;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ    = 2'd0,
      OP_DEQ    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               is_empty;
      status_type         status;
      logic [VALUE_W-1:0] value;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/core/fqr_mem.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module fqr_mem #(
   parameter int DEPTH      = fqr_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = fqr_pkg::DATA_WIDTH_DEF,
   localparam int AW        = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output      logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/fqr_ctrl.sv @@
// Sequencer: ring pointers, head-first scan and gap closing over the entry store.
`default_nettype none
module fqr_ctrl #(
   parameter int DEPTH      = fqr_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = fqr_pkg::DATA_WIDTH_DEF,
   localparam int AW        = $clog2(DEPTH),
   localparam int CW        = $clog2(DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [fqr_pkg::OP_W-1:0] req_op,
   input  wire logic [DATA_WIDTH-1:0] req_value,
   output      logic                  res_valid,
   input  wire logic                  res_ready,
   output      fqr_pkg::result_type   res,
   output      logic                  mem_we,
   output      logic [AW-1:0]         mem_waddr,
   output      logic [DATA_WIDTH-1:0] mem_wdata,
   output      logic                  mem_re,
   output      logic [AW-1:0]         mem_raddr,
   input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DEQ   = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   fqr_pkg::result_type   res_ff, res_in;

   logic [AW:0] count_k;
   logic [AW:0] next_k;
   logic [AW:0] skip_k;
   logic        scan_last;
   logic        shift_more;

   // logical position -> physical address in the ring
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW:0] k);
      logic [AW:0] sum;
      sum = {1'b0, base} + k;
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic fqr_pkg::result_type make_res(input logic [DATA_WIDTH-1:0] v,
                                                    input fqr_pkg::status_type st,
                                                    input logic [CW-1:0] cnt);
      logic [DATA_WIDTH+fqr_pkg::VALUE_W-1:0] v_wide;
      logic [CW+fqr_pkg::COUNT_W-1:0]         c_wide;
      fqr_pkg::result_type                    r;
      v_wide     = {{fqr_pkg::VALUE_W{1'b0}}, v};
      c_wide     = {{fqr_pkg::COUNT_W{1'b0}}, cnt};
      r.value    = v_wide[fqr_pkg::VALUE_W-1:0];
      r.status   = st;
      r.is_empty = (cnt == '0);
      r.count    = c_wide[fqr_pkg::COUNT_W-1:0];
      return r;
   endfunction

   assign count_k    = (AW+1)'(count_ff);
   assign next_k     = {1'b0, idx_ff} + (AW+1)'(1);
   assign skip_k     = {1'b0, idx_ff} + (AW+1)'(2);
   assign scan_last  = (next_k >= count_k);
   assign shift_more = (skip_k < count_k);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      value_in  = value_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = phys(head_ff, count_k);
      mem_wdata = req_value;
      mem_re    = 1'b0;
      mem_raddr = phys(head_ff, next_k);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               idx_in   = '0;
               case (req_op)
                  fqr_pkg::OP_ENQ: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_in = make_res('0, fqr_pkg::ST_FULL, count_ff);
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        res_in   = make_res('0, fqr_pkg::ST_OK, count_in);
                     end
                     state_in = S_DONE;
                  end
                  fqr_pkg::OP_DEQ: begin
                     if (count_ff == '0) begin
                        res_in   = make_res('0, fqr_pkg::ST_EMPTY, count_ff);
                        state_in = S_DONE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        state_in  = S_DEQ;
                     end
                  end
                  fqr_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        res_in   = make_res('0, fqr_pkg::ST_NOT_FOUND, count_ff);
                        state_in = S_DONE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     // unused request code: queue untouched
                     res_in   = make_res('0, fqr_pkg::ST_OK, count_ff);
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DEQ: begin
            head_in  = phys(head_ff, (AW+1)'(1));
            count_in = count_ff - CW'(1);
            res_in   = make_res(mem_rdata, fqr_pkg::ST_OK, count_in);
            state_in = S_DONE;
         end
         S_SCAN: begin
            // read of the next position goes out ahead of the compare
            mem_re = !scan_last;
            if (mem_rdata == value_ff) begin
               if (scan_last) begin
                  count_in = count_ff - CW'(1);
                  res_in   = make_res(value_ff, fqr_pkg::ST_OK, count_in);
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (scan_last) begin
               res_in   = make_res('0, fqr_pkg::ST_NOT_FOUND, count_ff);
               state_in = S_DONE;
            end else begin
               idx_in = next_k[AW-1:0];
            end
         end
         S_SHIFT: begin
            // entry idx+1 is on the read port; write it down to idx
            mem_we    = 1'b1;
            mem_waddr = phys(head_ff, {1'b0, idx_ff});
            mem_wdata = mem_rdata;
            if (shift_more) begin
               mem_re    = 1'b1;
               mem_raddr = phys(head_ff, skip_k);
               idx_in    = next_k[AW-1:0];
            end else begin
               count_in = count_ff - CW'(1);
               res_in   = make_res(value_ff, fqr_pkg::ST_OK, count_in);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      value_ff <= value_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule
`default_nettype wire

@@ rtl/core/fifo_queue_with_remove_core.sv @@
// Top level: tag queue with delete-by-value, stream ports and output register.
// Enqueue, refused, empty or unused-code requests go from idle straight to the result
// state; dequeue goes through a read state; remove scans held entries from the head
// and closes the gap on a match. The next request is taken in the cycle after the
// result leaves the sequencer; a full output register not drained by rsp_tready holds it.
// Synchronous active-high reset empties the queue; entry contents are not cleared.
`default_nettype none
module fifo_queue_with_remove_core #(
   parameter int DEPTH      = fqr_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = fqr_pkg::DATA_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // op[1:0], value[33:2], zero pad[39:34]
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata    // result_value[31:0], status[33:32],
                                         // is_empty[34], entry_count[39:35]
);

   localparam int AW = $clog2(DEPTH);

   logic [DATA_WIDTH+fqr_pkg::VALUE_W-1:0] req_value_wide;
   logic [DATA_WIDTH-1:0]                  req_value;
   logic [fqr_pkg::OP_W-1:0]               req_op;

   logic                  res_valid;
   logic                  res_ready;
   fqr_pkg::result_type   res;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] mem_rdata;

   logic                  rsp_valid_ff, rsp_valid_in;
   fqr_pkg::result_type   rsp_data_ff, rsp_data_in;
   logic                  rsp_load;

   // tags are held at DATA_WIDTH bits: zero-extend or drop upper bits
   assign req_op         = req_tdata[1:0];
   assign req_value_wide = {{DATA_WIDTH{1'b0}}, req_tdata[33:2]};
   assign req_value      = req_value_wide[DATA_WIDTH-1:0];

   fqr_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_op),
      .req_value (req_value),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   fqr_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // output register: the sequencer is free again while a result waits here
   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one request in flight: a transfer closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in flight");

   // a failed request never carries a tag
   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status != fqr_pkg::ST_OK) |-> (res.value == '0))
      else $error("non-ok result with nonzero value");

   // empty flag agrees with the count when the count is not truncated
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> ((DEPTH >= 32) || (res.is_empty == (res.count == '0))))
      else $error("empty flag disagrees with entry count");

   // the sequencer offers no result while it is taking requests
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !res_valid)
      else $error("result pending in idle state");

endmodule
`default_nettype wire
